FILE: hdl/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg
// Shared types, widths, operation codes and saturation helpers for the
// 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3au_pkg;

    localparam int CW         = 32;
    localparam int FB         = 16;
    localparam int SCALAR_W   = 64;
    localparam int PW         = 2 * CW;
    localparam int DW         = PW + 1;
    localparam int TERM_W     = 3 * CW + 2;
    localparam int SQ_STAGES  = CW;
    localparam int DIV_STAGES = FB + 1;
    localparam int NLANES     = 3;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_SCALE  = 4'd2;
    localparam logic [3:0] OP_DOT    = 4'd3;
    localparam logic [3:0] OP_CROSS  = 4'd4;
    localparam logic [3:0] OP_TRIPLE = 4'd5;
    localparam logic [3:0] OP_LENGTH = 4'd6;
    localparam logic [3:0] OP_NORM   = 4'd7;
    localparam logic [3:0] OP_PERP   = 4'd8;

    typedef logic signed [CW-1:0] t_comp;

    typedef struct packed {
        logic [3:0] operation;
        t_comp      a_x;
        t_comp      a_y;
        t_comp      a_z;
        t_comp      b_x;
        t_comp      b_y;
        t_comp      b_z;
        t_comp      c_x;
        t_comp      c_y;
        t_comp      c_z;
        t_comp      scale_factor;
    } t_in;

    typedef struct packed {
        t_comp                       result_x;
        t_comp                       result_y;
        t_comp                       result_z;
        logic signed [SCALAR_W-1:0]  result_scalar;
        logic                        test_true;
        logic                        zero_length_error;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        t_comp      ai;
        t_comp      aj;
        t_comp      ak;
        t_comp      bi;
        t_comp      bj;
        t_comp      bk;
        t_comp      cj;
        t_comp      ck;
        t_comp      sc;
    } t_lane_in;

    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        t_comp                    vec;
        logic [CW-1:0]            mag;
        logic                     neg;
        logic                     a_zero;
        logic                     b_zero;
    } t_lane_out;

    typedef struct packed {
        t_out                        res;
        logic                        is_len;
        logic                        norm_ok;
        logic [NLANES-1:0][CW-1:0]   mag;
        logic [NLANES-1:0]           neg;
    } t_side;

    typedef struct packed {
        t_out res;
        logic norm_ok;
    } t_post;

    function automatic t_comp f_sat32(input logic signed [TERM_W-1:0] v);
        t_comp r;
        if ((&v[TERM_W-1:CW-1]) || !(|v[TERM_W-1:CW-1])) begin
            r = v[CW-1:0];
        end else if (v[TERM_W-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SCALAR_W-1:0] f_sat64(
        input logic signed [TERM_W-1:0] v);
        logic signed [SCALAR_W-1:0] r;
        if ((&v[TERM_W-1:SCALAR_W-1]) || !(|v[TERM_W-1:SCALAR_W-1])) begin
            r = v[SCALAR_W-1:0];
        end else if (v[TERM_W-1]) begin
            r = {1'b1, {(SCALAR_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SCALAR_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: hdl/v3au_lane.sv
// ----------------------------------------------------------------------------
// v3au_lane
// One component lane: operand selection, two products, their difference,
// the second product stage for the triple product, and the lane's vector
// component with saturation.
// ----------------------------------------------------------------------------
module v3au_lane import v3au_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_lane_in  i_lane,
    output t_lane_out o_lane
);

    typedef struct packed {
        logic [3:0]     op;
        logic [CW:0]    as;
        t_comp          ai;
        logic           az;
        logic           bz;
    } t_carry;

    t_comp                 n_p0, n_q0, n_p1, n_q1;
    t_carry                n_c1;
    logic signed [PW-1:0]  r_m0, r_m1;
    t_carry                r_c1, r_c2, r_c3;
    logic [DW-1:0]         r_d2, r_d3;
    logic signed [DW-1:0]  r_pl3, r_ph3;
    logic signed [TERM_W-1:0] n_dx, n_ax;
    t_lane_out             n_out, r_out;

    always_comb begin
        n_p0 = i_lane.ai;
        n_q0 = i_lane.bi;
        n_p1 = '0;
        n_q1 = '0;
        case (i_lane.op) inside
            OP_SCALE: n_q0 = i_lane.sc;
            OP_CROSS: begin
                n_p0 = i_lane.aj;
                n_q0 = i_lane.bk;
                n_p1 = i_lane.ak;
                n_q1 = i_lane.bj;
            end
            OP_TRIPLE: begin
                n_p0 = i_lane.bj;
                n_q0 = i_lane.ck;
                n_p1 = i_lane.bk;
                n_q1 = i_lane.cj;
            end
            OP_LENGTH, OP_NORM: n_q0 = i_lane.ai;
            default: ;
        endcase
        n_c1.op = i_lane.op;
        n_c1.ai = i_lane.ai;
        n_c1.az = (i_lane.ai == '0);
        n_c1.bz = (i_lane.bi == '0);
        if (i_lane.op == OP_SUB) begin
            n_c1.as = {i_lane.ai[CW-1], i_lane.ai} - {i_lane.bi[CW-1], i_lane.bi};
        end else begin
            n_c1.as = {i_lane.ai[CW-1], i_lane.ai} + {i_lane.bi[CW-1], i_lane.bi};
        end
    end

    always_comb begin
        n_dx = $signed({{(TERM_W-DW){r_d3[DW-1]}}, r_d3});
        n_ax = $signed({{(TERM_W-CW-1){r_c3.as[CW]}}, r_c3.as});
        n_out.term = n_dx;
        if (r_c3.op == OP_TRIPLE) begin
            n_out.term = $signed({r_ph3[DW-1], r_ph3, {CW{1'b0}}})
                       + $signed({{(TERM_W-DW){r_pl3[DW-1]}}, r_pl3});
        end
        case (r_c3.op) inside
            OP_ADD, OP_SUB:     n_out.vec = f_sat32(n_ax);
            OP_SCALE, OP_CROSS: n_out.vec = f_sat32(n_dx >>> FB);
            default:            n_out.vec = '0;
        endcase
        n_out.mag    = r_c3.ai[CW-1] ? CW'(~r_c3.ai + 1'b1) : r_c3.ai;
        n_out.neg    = r_c3.ai[CW-1];
        n_out.a_zero = r_c3.az;
        n_out.b_zero = r_c3.bz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= PW'(n_p0) * PW'(n_q0);
            r_m1  <= PW'(n_p1) * PW'(n_q1);
            r_c1  <= n_c1;
            r_d2  <= {r_m0[PW-1], r_m0} - {r_m1[PW-1], r_m1};
            r_c2  <= r_c1;
            r_pl3 <= DW'($signed({1'b0, r_d2[CW-1:0]})) * DW'(r_c2.ai);
            r_ph3 <= DW'($signed(r_d2[DW-1:CW])) * DW'(r_c2.ai);
            r_d3  <= r_d2;
            r_c3  <= r_c2;
            r_out <= n_out;
        end
    end

    assign o_lane = r_out;

endmodule

FILE: hdl/v3au_sqrt.sv
// ----------------------------------------------------------------------------
// v3au_sqrt
// Pipelined integer square root, one result bit per stage, floor of the
// exact root of a 64-bit sum of squares. Side data travels alongside.
// ----------------------------------------------------------------------------
module v3au_sqrt import v3au_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [PW-1:0]     i_x,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [CW-1:0]     o_root,
    output t_side             o_side
);

    logic [PW-1:0]    r_x    [SQ_STAGES];
    logic [CW+3:0]    r_rem  [SQ_STAGES];
    logic [CW-1:0]    r_root [SQ_STAGES];
    t_side            r_side [SQ_STAGES];
    logic             r_v    [SQ_STAGES];
    logic [PW-1:0]    n_x    [SQ_STAGES];
    logic [CW+3:0]    n_rem  [SQ_STAGES];
    logic [CW-1:0]    n_root [SQ_STAGES];

    always_comb begin
        logic [PW-1:0] px;
        logic [CW+3:0] prem, rem2, trial;
        logic [CW-1:0] proot;
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                px    = i_x;
                prem  = '0;
                proot = '0;
            end else begin
                px    = r_x[s-1];
                prem  = r_rem[s-1];
                proot = r_root[s-1];
            end
            rem2  = {prem[CW+1:0], px[PW-1:PW-2]};
            trial = {2'b00, proot, 2'b01};
            if (rem2 >= trial) begin
                n_rem[s]  = rem2 - trial;
                n_root[s] = {proot[CW-2:0], 1'b1};
            end else begin
                n_rem[s]  = rem2;
                n_root[s] = {proot[CW-2:0], 1'b0};
            end
            n_x[s] = {px[PW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < SQ_STAGES; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_x[s]    <= n_x[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                if (s > 0) begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

FILE: hdl/v3au_div.sv
// ----------------------------------------------------------------------------
// v3au_div
// Pipelined restoring divider for one normalize component: the magnitude
// shifted up by the fraction bits over the length, one quotient bit per
// stage, with the sign applied at the end.
// ----------------------------------------------------------------------------
module v3au_div import v3au_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [CW-1:0] i_mag,
    input  logic [CW-1:0] i_len,
    input  logic          i_neg,
    output t_comp         o_quot
);

    logic [CW-1:0]         r_r [DIV_STAGES];
    logic [CW-1:0]         r_d [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_q [DIV_STAGES];
    logic                  r_n [DIV_STAGES];
    logic [CW-1:0]         n_r [DIV_STAGES];
    logic [DIV_STAGES-1:0] n_q [DIV_STAGES];
    logic [CW-1:0]         w_q;

    always_comb begin
        logic [CW-1:0]         pr, pd;
        logic [DIV_STAGES-1:0] pq;
        logic                  nb;
        logic [CW:0]           rs, dd;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                pr = {1'b0, i_mag[CW-1:1]};
                pd = i_len;
                pq = '0;
                nb = i_mag[0];
            end else begin
                pr = r_r[s-1];
                pd = r_d[s-1];
                pq = r_q[s-1];
                nb = 1'b0;
            end
            rs = {pr, nb};
            dd = {1'b0, pd};
            if (rs >= dd) begin
                n_r[s] = CW'(rs - dd);
                n_q[s] = {pq[DIV_STAGES-2:0], 1'b1};
            end else begin
                n_r[s] = rs[CW-1:0];
                n_q[s] = {pq[DIV_STAGES-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_len;
            r_n[0] <= i_neg;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_r[s] <= n_r[s];
                r_q[s] <= n_q[s];
                if (s > 0) begin
                    r_d[s] <= r_d[s-1];
                    r_n[s] <= r_n[s-1];
                end
            end
        end
    end

    assign w_q    = {{(CW-DIV_STAGES){1'b0}}, r_q[DIV_STAGES-1]};
    assign o_quot = r_n[DIV_STAGES-1] ? CW'(~w_q + 1'b1) : w_q;

endmodule

FILE: hdl/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Pipeline: four lane stages, one merge stage, the 32-stage square root
// pipeline and the 17-stage divider, all held while o_stall is high.
// Throughput: one transaction per cycle while o_stall is low; a two-entry
// output buffer keeps the input open while one result waits.
// Reset: synchronous, active low; clears all valid flags and the buffer.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit import v3au_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_result
);

    logic                     w_en;
    t_comp                    w_a [NLANES];
    t_comp                    w_b [NLANES];
    t_comp                    w_c [NLANES];
    t_lane_in                 w_lin  [NLANES];
    t_lane_out                w_lout [NLANES];
    t_comp                    w_quot [NLANES];
    logic                     r_lv  [4];
    logic [3:0]               r_lop [4];
    logic signed [TERM_W-1:0] n_sum;
    t_side                    n_mside, r_mside;
    logic                     r_mv;
    logic [PW-1:0]            r_mx;
    logic                     w_sq_v;
    logic [CW-1:0]            w_root;
    t_side                    w_sq_side;
    t_post                    n_post;
    logic                     r_dv [DIV_STAGES];
    t_post                    r_dp [DIV_STAGES];
    t_out                     n_fin;
    logic                     w_push, w_pop;
    logic [1:0]               r_cnt;
    t_out                     r_e0, r_e1;

    assign w_en    = (r_cnt != 2'd2);
    assign o_stall = !w_en;

    assign w_a[0] = i_item.a_x;
    assign w_a[1] = i_item.a_y;
    assign w_a[2] = i_item.a_z;
    assign w_b[0] = i_item.b_x;
    assign w_b[1] = i_item.b_y;
    assign w_b[2] = i_item.b_z;
    assign w_c[0] = i_item.c_x;
    assign w_c[1] = i_item.c_y;
    assign w_c[2] = i_item.c_z;

    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        localparam int LJ = (g + 1) % NLANES;
        localparam int LK = (g + 2) % NLANES;
        assign w_lin[g] = '{op: i_item.operation, ai: w_a[g], aj: w_a[LJ], ak: w_a[LK],
                            bi: w_b[g], bj: w_b[LJ], bk: w_b[LK],
                            cj: w_c[LJ], ck: w_c[LK], sc: i_item.scale_factor};
        v3au_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_lin[g]),
            .o_lane (w_lout[g])
        );
        v3au_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (w_sq_side.mag[g]),
            .i_len  (w_root),
            .i_neg  (w_sq_side.neg[g]),
            .o_quot (w_quot[g])
        );
    end

    always_comb begin
        logic a_zero, b_zero;
        a_zero = w_lout[0].a_zero && w_lout[1].a_zero && w_lout[2].a_zero;
        b_zero = w_lout[0].b_zero && w_lout[1].b_zero && w_lout[2].b_zero;
        n_sum  = w_lout[0].term + w_lout[1].term + w_lout[2].term;
        n_mside = '0;
        for (int l = 0; l < NLANES; l++) begin
            n_mside.mag[l] = w_lout[l].mag;
            n_mside.neg[l] = w_lout[l].neg;
        end
        case (r_lop[3]) inside
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
                n_mside.res.result_x = w_lout[0].vec;
                n_mside.res.result_y = w_lout[1].vec;
                n_mside.res.result_z = w_lout[2].vec;
            end
            OP_DOT:    n_mside.res.result_scalar = f_sat64(n_sum >>> FB);
            OP_TRIPLE: n_mside.res.result_scalar = f_sat64(n_sum >>> (2 * FB));
            OP_LENGTH: n_mside.is_len = 1'b1;
            OP_NORM: begin
                n_mside.res.zero_length_error = a_zero;
                n_mside.norm_ok               = !a_zero;
            end
            OP_PERP: begin
                n_mside.res.zero_length_error = a_zero || b_zero;
                n_mside.res.test_true         = !(a_zero || b_zero) && (n_sum == '0);
            end
            default: ;
        endcase
    end

    v3au_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mv),
        .i_x     (r_mx),
        .i_side  (r_mside),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    always_comb begin
        n_post.res     = w_sq_side.res;
        n_post.norm_ok = w_sq_side.norm_ok;
        if (w_sq_side.is_len) begin
            n_post.res.result_scalar = {{(SCALAR_W-CW){1'b0}}, w_root};
        end
        n_fin = r_dp[DIV_STAGES-1].res;
        if (r_dp[DIV_STAGES-1].norm_ok) begin
            n_fin.result_x = w_quot[0];
            n_fin.result_y = w_quot[1];
            n_fin.result_z = w_quot[2];
        end
    end

    assign w_push = w_en && r_dv[DIV_STAGES-1];
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_lv[s] <= 1'b0;
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_mv  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_en) begin
                r_lv[0] <= i_valid;
                for (int s = 1; s < 4; s++) begin
                    r_lv[s] <= r_lv[s-1];
                end
                r_mv    <= r_lv[3];
                r_dv[0] <= w_sq_v;
                for (int s = 1; s < DIV_STAGES; s++) begin
                    r_dv[s] <= r_dv[s-1];
                end
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lop[0] <= i_item.operation;
            for (int s = 1; s < 4; s++) begin
                r_lop[s] <= r_lop[s-1];
            end
            r_mside <= n_mside;
            r_mx    <= n_sum[PW-1:0];
            r_dp[0] <= n_post;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dp[s] <= r_dp[s-1];
            end
        end
        if (w_push && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop))) begin
            r_e0 <= n_fin;
        end else if (w_pop) begin
            r_e0 <= r_e1;
        end
        if (w_push && (r_cnt == 2'd1) && !w_pop) begin
            r_e1 <= n_fin;
        end
    end

    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_e0;

endmodule

FILE: hdl/v3au_checker.sv
// ----------------------------------------------------------------------------
// v3au_checker
// Port-level checks for the vector arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module v3au_checker import v3au_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_result
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("Stalled output transaction changed or dropped.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Output buffer not empty after reset.");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.zero_length_error |->
            o_result.result_x == '0 && o_result.result_y == '0 &&
            o_result.result_z == '0 && o_result.result_scalar == '0 &&
            !o_result.test_true)
        else $error("Zero-length error carries nonzero result fields.");

    a_test_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.test_true |->
            o_result.result_x == '0 && o_result.result_y == '0 &&
            o_result.result_z == '0 && o_result.result_scalar == '0)
        else $error("Perpendicular result carries nonzero fields.");

endmodule

bind vector3_arithmetic_unit v3au_checker u_checker (.*);

FILE: bench/vector3_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_test
// Drives directed and random vector transactions through the 3D vector
// arithmetic unit under varying source and sink stalls, and compares every
// result field against a bit-exact fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_test;
    import v3au_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 70;

    typedef logic signed [127:0] t_wide;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_result;

    t_out expected_results[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    vector3_arithmetic_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_comp clamp32(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = 128'sh7FFF_FFFF;
        lo = -128'sh8000_0000;
        if (v > hi) return t_comp'(32'h7FFF_FFFF);
        if (v < lo) return t_comp'(32'h8000_0000);
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] clamp64(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = 128'sh7FFF_FFFF_FFFF_FFFF;
        lo = -128'sh8000_0000_0000_0000;
        if (v > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (v < lo) return 64'sh8000_0000_0000_0000;
        return v[63:0];
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out compute_vector_result(input t_in it);
        t_out  r;
        t_wide a[3];
        t_wide b[3];
        t_wide c[3];
        t_wide v[3];
        t_wide s;
        t_wide sc;
        longint unsigned sq_a;
        longint unsigned sq_b;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned q;
        t_comp res[3];
        int j;
        int k;
        r = '0;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        c[0] = it.c_x; c[1] = it.c_y; c[2] = it.c_z;
        sc = it.scale_factor;
        res[0] = '0; res[1] = '0; res[2] = '0;
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        sq_a = s[63:0];
        s = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        sq_b = s[63:0];
        case (it.operation)
            OP_ADD: for (int i = 0; i < 3; i++) res[i] = clamp32(a[i] + b[i]);
            OP_SUB: for (int i = 0; i < 3; i++) res[i] = clamp32(a[i] - b[i]);
            OP_SCALE: for (int i = 0; i < 3; i++) res[i] = clamp32((a[i] * sc) >>> FB);
            OP_DOT: r.result_scalar = clamp64((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FB);
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    res[i] = clamp32((a[j] * b[k] - a[k] * b[j]) >>> FB);
                end
            end
            OP_TRIPLE: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    v[i] = b[j] * c[k] - b[k] * c[j];
                end
                s = v[0] * a[0] + v[1] * a[1] + v[2] * a[2];
                r.result_scalar = clamp64(s >>> (2 * FB));
            end
            OP_LENGTH: r.result_scalar = root_floor(sq_a);
            OP_NORM: begin
                if (sq_a == 0) begin
                    r.zero_length_error = 1'b1;
                end else begin
                    len = root_floor(sq_a);
                    for (int i = 0; i < 3; i++) begin
                        mag = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
                        q = (mag << FB) / len;
                        res[i] = clamp32((a[i] < 0) ? -t_wide'(q) : t_wide'(q));
                    end
                end
            end
            OP_PERP: begin
                if (sq_a == 0 || sq_b == 0) begin
                    r.zero_length_error = 1'b1;
                end else begin
                    r.test_true = ((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) == 0);
                end
            end
            default: ;
        endcase
        r.result_x = res[0];
        r.result_y = res[1];
        r.result_z = res[2];
        return r;
    endfunction

    task automatic send_item(input t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(compute_vector_result(it));
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                mismatch_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_result.result_x !== e.result_x) begin
                    $error("result_x expected %0d actual %0d", e.result_x, o_result.result_x);
                    mismatch_count++;
                end
                if (o_result.result_y !== e.result_y) begin
                    $error("result_y expected %0d actual %0d", e.result_y, o_result.result_y);
                    mismatch_count++;
                end
                if (o_result.result_z !== e.result_z) begin
                    $error("result_z expected %0d actual %0d", e.result_z, o_result.result_z);
                    mismatch_count++;
                end
                if (o_result.result_scalar !== e.result_scalar) begin
                    $error("result_scalar expected %0d actual %0d",
                           e.result_scalar, o_result.result_scalar);
                    mismatch_count++;
                end
                if (o_result.test_true !== e.test_true) begin
                    $error("test_true expected %0b actual %0b", e.test_true,
                           o_result.test_true);
                    mismatch_count++;
                end
                if (o_result.zero_length_error !== e.zero_length_error) begin
                    $error("zero_length_error expected %0b actual %0b",
                           e.zero_length_error, o_result.zero_length_error);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic t_comp random_component();
        case ($urandom_range(4))
            0: return t_comp'($urandom);
            1: return t_comp'(int'($urandom_range(1 << 20)) - (1 << 19));
            2: return t_comp'(int'($urandom_range(1 << 12)) - (1 << 11));
            3: begin
                case ($urandom_range(4))
                    0: return t_comp'(32'h7FFF_FFFF);
                    1: return t_comp'(32'h8000_0000);
                    2: return t_comp'(0);
                    3: return t_comp'(1);
                    default: return t_comp'(-1);
                endcase
            end
            default: return t_comp'(int'($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        it.operation = ($urandom_range(19) == 0) ? 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))
                                                  : 4'($urandom_range(OP_PERP, OP_ADD));
        it.a_x = random_component(); it.a_y = random_component(); it.a_z = random_component();
        it.b_x = random_component(); it.b_y = random_component(); it.b_z = random_component();
        it.c_x = random_component(); it.c_y = random_component(); it.c_z = random_component();
        it.scale_factor = random_component();
        if ($urandom_range(9) == 0) begin
            it.a_x = '0; it.a_y = '0; it.a_z = '0;
        end else if ((it.operation == OP_PERP) && $urandom_range(2) == 0) begin
            it.a_z = '0;
            it.b_x = -it.a_y;
            it.b_y = it.a_x;
        end else if ((it.operation == OP_PERP) && $urandom_range(5) == 0) begin
            it.b_x = '0; it.b_y = '0; it.b_z = '0;
        end
        return it;
    endfunction

    function automatic t_in make_item(input logic [3:0] op, input t_comp ax, input t_comp ay,
                                      input t_comp az, input t_comp bx, input t_comp by,
                                      input t_comp bz, input t_comp sc);
        t_in it;
        it = '0;
        it.operation = op;
        it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz;
        it.c_x = bx; it.c_y = bz; it.c_z = ay;
        it.scale_factor = sc;
        return it;
    endfunction

    task automatic test_directed();
        t_comp mx;
        t_comp mn;
        t_comp one;
        mx  = t_comp'(32'h7FFF_FFFF);
        mn  = t_comp'(32'h8000_0000);
        one = t_comp'(32'h0001_0000);
        send_item(make_item(OP_ADD, mx, mn, one, mx, mn, -one, '0));
        send_item(make_item(OP_SUB, mn, mx, one, mx, mn, one, '0));
        send_item(make_item(OP_SCALE, mx, mn, one, '0, '0, '0, mn));
        send_item(make_item(OP_SCALE, -one, mx, 3, '0, '0, '0, -one));
        send_item(make_item(OP_DOT, mn, mn, mn, mn, mn, mn, '0));
        send_item(make_item(OP_DOT, mx, mn, mx, mn, mx, mn, '0));
        send_item(make_item(OP_CROSS, mx, mn, mx, mn, mx, mn, '0));
        send_item(make_item(OP_CROSS, one, '0, '0, '0, one, '0, '0));
        send_item(make_item(OP_TRIPLE, mn, mx, mn, mx, mn, mx, '0));
        send_item(make_item(OP_TRIPLE, one, one, -one, one, -one, one, '0));
        send_item(make_item(OP_LENGTH, mn, mn, mn, '0, '0, '0, '0));
        send_item(make_item(OP_LENGTH, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(OP_NORM, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(OP_NORM, 1, '0, '0, '0, '0, '0, '0));
        send_item(make_item(OP_NORM, mn, mx, -1, '0, '0, '0, '0));
        send_item(make_item(OP_PERP, '0, '0, '0, one, one, one, '0));
        send_item(make_item(OP_PERP, one, one, one, '0, '0, '0, '0));
        send_item(make_item(OP_PERP, one, '0, '0, '0, one, '0, '0));
        send_item(make_item(OP_PERP, one, 1, '0, one, '0, '0, '0));
        send_item(make_item(OP_UNUSED_LO, mx, mx, mx, mx, mx, mx, mx));
        send_item(make_item(OP_UNUSED_HI, mn, mn, mn, mn, mn, mn, mn));
        wait_until_drained();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) send_item(random_item());
        wait_until_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(370, 27, 69);
        test_random(370, 69, 27);
        test_random(370, 0, 0);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/v3au_pkg.sv
hdl/v3au_lane.sv
hdl/v3au_sqrt.sv
hdl/v3au_div.sv
hdl/vector3_arithmetic_unit.sv
hdl/v3au_checker.sv
bench/vector3_arithmetic_unit_test.sv
